FILE: design/krl_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// krl_pkg: shared types and constants of the keyed rate limiter
// Beat payloads, register map codes and scan-unit control/flag structs.
// ----------------------------------------------------------------------------
package krl_pkg;

  localparam int KEY_W  = 32;
  localparam int TICK_W = 32;
  localparam int REP_W  = 16;
  localparam int CNT_W  = 5;
  localparam int CFG_W  = 32;
  localparam int ADDR_W = 3;

  localparam logic [REP_W-1:0]  REP_MAX        = '1;
  localparam logic [TICK_W-1:0] INTERVAL_RESET = 32'd1000;
  localparam logic [CNT_W-1:0]  CAPACITY_RESET = 5'd16;

  // register select is paddr[2]
  localparam logic REG_INTERVAL = 1'b0;
  localparam logic REG_CAPACITY = 1'b1;

  typedef struct packed {
    logic [KEY_W-1:0]  key_id;
    logic [TICK_W-1:0] now_ticks;
  } krl_req_t;

  typedef struct packed {
    logic              emit;
    logic [REP_W-1:0]  suppressed_count;
    logic              rejected;
    logic [CNT_W-1:0]  tracked_keys;
  } krl_res_t;

  typedef enum logic {
    MODE_LOOK = 1'b0,   // key search pass
    MODE_AGE  = 1'b1    // rank update / eviction pass
  } scan_mode_t;

  typedef struct packed {
    scan_mode_t mode;
    logic       touch;  // key was found: age entries more recent than it
    logic       trim;   // table at capacity: evict the oldest ranks
  } scan_ctl_t;

  typedef struct packed {
    logic match;  // valid entry holding the search key
    logic bump;   // rank ages by one, write back
    logic evict;  // entry drops out of the table
    logic free;   // slot usable for the new key
  } scan_flags_t;

endpackage

FILE: design/krl_entry_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// krl_entry_ram: entry table storage
// One write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module krl_entry_ram #(
  parameter int   DEPTH = 16,
  parameter int   WIDTH = 84,
  localparam int  AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

FILE: design/krl_scan_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// krl_scan_unit: per-entry compare and rank update
// Shared by both table passes; sees one entry per cycle.
// ----------------------------------------------------------------------------
module krl_scan_unit import krl_pkg::*; #(
  parameter int RANK_W = 4
) (
  input  scan_ctl_t         ctl,
  input  logic              entry_valid,
  input  logic [KEY_W-1:0]  entry_key,
  input  logic [RANK_W-1:0] entry_rank,
  input  logic [KEY_W-1:0]  search_key,
  input  logic [RANK_W-1:0] hit_rank,
  input  logic [RANK_W-1:0] cap_m1,
  output scan_flags_t       flags,
  output logic [RANK_W-1:0] rank_next
);

  logic evict;

  assign evict     = (ctl.mode == MODE_AGE) && !ctl.touch && ctl.trim && entry_valid &&
                     (entry_rank >= cap_m1);
  assign rank_next = entry_rank + RANK_W'(1);

  always_comb begin
    flags = '0;
    unique case (ctl.mode)
      MODE_LOOK: begin
        flags.match = entry_valid && (entry_key == search_key);
      end
      MODE_AGE: begin
        flags.evict = evict;
        flags.free  = !ctl.touch && (!entry_valid || evict);
        flags.bump  = entry_valid && (ctl.touch ? (entry_rank < hit_rank) : !evict);
      end
      default: flags = '0;
    endcase
  end

endmodule

FILE: design/keyed_rate_limiter_lru.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// keyed_rate_limiter_lru: per-key event rate limiter with LRU eviction
// Tracks up to TABLE_DEPTH keys; emits or suppresses each event by key age.
// ----------------------------------------------------------------------------
//
//  channel   signals                               direction  beat when
//  -------   -----------------------------------   ---------  ---------------------
//  request   start, busy, req                      in         start && !busy
//  result    done, result                          out        done (one cycle)
//  config    psel, penable, pwrite, paddr,         in/out     psel && penable &&
//            pwdata, prdata, pready                           pwrite (pready = 1)
//
//  A nonzero key keeps busy high through a search pass and an aging/eviction
//  pass over the single-read-port entry RAM, one entry per cycle, then a
//  final entry update in ST_WRITE.
//  The result beat comes in the same cycle that busy drops.
//  Key 0 is rejected in the next cycle, table untouched, busy stays low.
//  Reset clears the valid bits, entry count and registers at once; no sweep.
//  The result receiver cannot stall; done is a single-cycle strobe.
//
//  Register map (32-bit, selected by paddr[2]):
//    0x0 interval_ticks  minimum ticks between emits of one key
//    0x4 key_capacity    entries in use before eviction (5 bits)
//
module keyed_rate_limiter_lru import krl_pkg::*; #(
  parameter int TABLE_DEPTH = 16,
  parameter int COUNT_BITS  = 16
) (
  input  logic              clk,
  input  logic              rst,
  // request
  input  logic              start,
  input  krl_req_t          req,
  output logic              busy,
  // result
  output logic              done,
  output krl_res_t          result,
  // configuration
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [CFG_W-1:0]  pwdata,
  output logic [CFG_W-1:0]  prdata,
  output logic              pready
);

  localparam int IDX_W  = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int STEP_W = $clog2(TABLE_DEPTH + 1);
  localparam int ENT_W  = KEY_W + TICK_W + COUNT_BITS + IDX_W;
  localparam int SUP_W  = (COUNT_BITS > REP_W) ? COUNT_BITS : REP_W;

  typedef enum logic [3:0] {
    ST_IDLE  = 4'b0001,
    ST_LOOK  = 4'b0010,
    ST_AGE   = 4'b0100,
    ST_WRITE = 4'b1000
  } state_t;

  // entry layout in RAM: key | last emit | suppressed | rank
  typedef struct packed {
    logic [KEY_W-1:0]      key;
    logic [TICK_W-1:0]     last;
    logic [COUNT_BITS-1:0] supp;
    logic [IDX_W-1:0]      rank;
  } entry_t;

  state_t state;

  // configuration registers
  logic [TICK_W-1:0] interval_ticks;
  logic [CNT_W-1:0]  key_capacity;

  // table control
  logic [TABLE_DEPTH-1:0] valid;
  logic [CNT_W-1:0]       count;

  // item being worked on
  logic [KEY_W-1:0]      key_q;
  logic [TICK_W-1:0]     now_q;
  logic                  hit;
  logic [IDX_W-1:0]      hit_idx;
  logic [IDX_W-1:0]      hit_rank;
  logic [TICK_W-1:0]     hit_last;
  logic [COUNT_BITS-1:0] hit_supp;
  logic                  slot_found;
  logic [IDX_W-1:0]      slot_idx;
  logic                  trim;

  // scan sequencing: step k reads entry k, processes entry k-1
  logic [STEP_W-1:0] step;
  logic [STEP_W-1:0] step_m1;
  logic [IDX_W-1:0]  proc_idx;
  logic              proc_valid;
  logic              scan_last;

  // RAM ports
  logic             ram_we;
  logic [IDX_W-1:0] ram_waddr;
  entry_t           ram_wdata;
  entry_t           ram_q;

  // scan unit
  scan_ctl_t        scan_ctl;
  scan_flags_t      flags;
  logic [IDX_W-1:0] rank_next;

  // capacity and update math
  logic [8:0]            cap_ext;
  logic [CNT_W-1:0]      cap_eff;
  logic [IDX_W-1:0]      cap_m1;
  logic [TICK_W-1:0]     elapsed;
  logic                  due;
  logic [COUNT_BITS-1:0] supp_inc;
  logic [SUP_W-1:0]      supp_ext;
  logic [REP_W-1:0]      rep;
  logic [CNT_W-1:0]      count_ins;
  logic                  accept;

  assign busy   = (state != ST_IDLE);
  assign accept = start && !busy;
  assign pready = 1'b1;

  // ---------------------------------------------------------------------------
  // APB register file: write on the access phase, reads are combinational
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      interval_ticks <= INTERVAL_RESET;
      key_capacity   <= CAPACITY_RESET;
    end else if (psel && penable && pwrite && pready) begin
      unique case (paddr[2])
        REG_INTERVAL: interval_ticks <= pwdata;
        REG_CAPACITY: key_capacity   <= pwdata[CNT_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    prdata = '0;
    unique case (paddr[2])
      REG_INTERVAL: prdata = interval_ticks;
      REG_CAPACITY: prdata = CFG_W'(key_capacity);
      default:      prdata = '0;
    endcase
  end

  // ---------------------------------------------------------------------------
  // Capacity clamp: zero acts as one, anything above the table as the table
  // ---------------------------------------------------------------------------
  assign cap_ext = 9'(key_capacity);

  always_comb begin
    if (key_capacity == '0) begin
      cap_eff = CNT_W'(1);
    end else if (cap_ext > 9'(TABLE_DEPTH)) begin
      cap_eff = CNT_W'(TABLE_DEPTH);
    end else begin
      cap_eff = key_capacity;
    end
  end

  assign cap_m1    = IDX_W'(cap_eff - CNT_W'(1));
  assign count_ins = (count < cap_eff) ? (count + CNT_W'(1)) : cap_eff;

  // ---------------------------------------------------------------------------
  // Scan stepping
  // ---------------------------------------------------------------------------
  assign step_m1    = step - STEP_W'(1);
  assign proc_idx   = step_m1[IDX_W-1:0];
  assign proc_valid = (step != '0);
  assign scan_last  = (step == STEP_W'(TABLE_DEPTH));

  assign scan_ctl.mode  = (state == ST_AGE) ? MODE_AGE : MODE_LOOK;
  assign scan_ctl.touch = hit;
  assign scan_ctl.trim  = trim;

  krl_scan_unit #(
    .RANK_W (IDX_W)
  ) u_scan (
    .ctl         (scan_ctl),
    .entry_valid (valid[proc_idx] && proc_valid),
    .entry_key   (ram_q.key),
    .entry_rank  (ram_q.rank),
    .search_key  (key_q),
    .hit_rank    (hit_rank),
    .cap_m1      (cap_m1),
    .flags       (flags),
    .rank_next   (rank_next)
  );

  // ---------------------------------------------------------------------------
  // Emit decision for a known key: time went backwards or interval elapsed
  // ---------------------------------------------------------------------------
  assign elapsed  = now_q - hit_last;
  assign due      = (now_q < hit_last) || (elapsed >= interval_ticks);
  assign supp_inc = (hit_supp == '1) ? hit_supp : (hit_supp + COUNT_BITS'(1));
  assign supp_ext = SUP_W'(hit_supp);
  assign rep      = (supp_ext > SUP_W'(REP_MAX)) ? REP_MAX : supp_ext[REP_W-1:0];

  // ---------------------------------------------------------------------------
  // Entry RAM: rank write-backs during aging, one entry update at the end
  // ---------------------------------------------------------------------------
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = proc_idx;
    ram_wdata = ram_q;
    if (state == ST_AGE) begin
      ram_we         = proc_valid && flags.bump;
      ram_wdata.rank = rank_next;
    end else if (state == ST_WRITE) begin
      ram_we         = 1'b1;
      ram_waddr      = hit ? hit_idx : slot_idx;
      ram_wdata.key  = key_q;
      ram_wdata.rank = '0;
      if (!hit || due) begin
        ram_wdata.last = now_q;
        ram_wdata.supp = '0;
      end else begin
        ram_wdata.last = hit_last;
        ram_wdata.supp = supp_inc;
      end
    end
  end

  krl_entry_ram #(
    .DEPTH (TABLE_DEPTH),
    .WIDTH (ENT_W)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (step[IDX_W-1:0]),
    .rdata (ram_q)
  );

  // ---------------------------------------------------------------------------
  // Sequencer
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      valid <= '0;
      count <= '0;
      done  <= 1'b0;
      step  <= '0;
    end else begin
      done <= 1'b0;
      unique case (state)
        ST_IDLE: begin
          step <= '0;
          if (accept) begin
            if (req.key_id == '0) begin
              // empty key: answer at once, table untouched
              done                    <= 1'b1;
              result.emit             <= 1'b0;
              result.suppressed_count <= '0;
              result.rejected         <= 1'b1;
              result.tracked_keys     <= count;
            end else begin
              state      <= ST_LOOK;
              key_q      <= req.key_id;
              now_q      <= req.now_ticks;
              hit        <= 1'b0;
              slot_found <= 1'b0;
            end
          end
        end
        ST_LOOK: begin
          if (proc_valid && flags.match && !hit) begin
            hit      <= 1'b1;
            hit_idx  <= proc_idx;
            hit_rank <= ram_q.rank;
            hit_last <= ram_q.last;
            hit_supp <= ram_q.supp;
          end
          if (scan_last) begin
            state <= ST_AGE;
            step  <= '0;
            trim  <= (count >= cap_eff);
          end else begin
            step <= step + STEP_W'(1);
          end
        end
        ST_AGE: begin
          if (proc_valid && flags.evict) begin
            valid[proc_idx] <= 1'b0;
          end
          if (proc_valid && flags.free && !slot_found) begin
            slot_found <= 1'b1;
            slot_idx   <= proc_idx;
          end
          if (scan_last) begin
            state <= ST_WRITE;
            step  <= '0;
          end else begin
            step <= step + STEP_W'(1);
          end
        end
        ST_WRITE: begin
          state           <= ST_IDLE;
          done            <= 1'b1;
          result.rejected <= 1'b0;
          if (hit) begin
            result.emit             <= due;
            result.suppressed_count <= due ? rep : '0;
            result.tracked_keys     <= count;
          end else begin
            valid[slot_idx]         <= 1'b1;
            count                   <= count_ins;
            result.emit             <= 1'b1;
            result.suppressed_count <= '0;
            result.tracked_keys     <= count_ins;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
  a_count_matches_valid: assert property (@(posedge clk) disable iff (rst)
    (state == ST_IDLE) |-> ($countones(valid) == count))
    else $error("entry count disagrees with valid bits");

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(TABLE_DEPTH))
    else $error("entry count above table depth");

  a_reject_next: assert property (@(posedge clk) disable iff (rst)
    (accept && (req.key_id == '0)) |=> (done && result.rejected && !result.emit))
    else $error("empty key not rejected in next cycle");

  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    done |-> !busy)
    else $error("result beat while busy");

  a_insert_slot: assert property (@(posedge clk) disable iff (rst)
    (state == ST_WRITE && !hit) |-> slot_found)
    else $error("insert without a free slot");

endmodule

FILE: verif/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for keyed_rate_limiter_lru
// Drives key/timestamp beats through the start/busy port and predicts each
// verdict with a shadow LRU table. Config goes over APB between phases.
// Directed cases cover the empty key, emit/suppress rules, the interval
// extremes and capacity limits. Random phases follow, with random sender gaps.
// ----------------------------------------------------------------------------
module tb_top;
  import krl_pkg::*;

  localparam int DEPTH = 16;

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              start = 1'b0;
  krl_req_t          req = '0;
  logic              busy;
  logic              done;
  krl_res_t          result;
  logic              psel = 1'b0;
  logic              penable = 1'b0;
  logic              pwrite = 1'b0;
  logic [ADDR_W-1:0] paddr = '0;
  logic [CFG_W-1:0]  pwdata = '0;
  logic [CFG_W-1:0]  prdata;
  logic              pready;

  keyed_rate_limiter_lru u_dut (
    .clk     (clk),
    .rst     (rst),
    .start   (start),
    .req     (req),
    .busy    (busy),
    .done    (done),
    .result  (result),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // --------------------------------------------------------------------------
  // Shadow table: mirrors the per-key records and LRU ranks of the block.
  // Rank 0 is the most recently touched entry.
  // --------------------------------------------------------------------------
  logic              shadow_valid [DEPTH];
  logic [KEY_W-1:0]  shadow_key   [DEPTH];
  logic [TICK_W-1:0] shadow_last  [DEPTH];
  logic [REP_W-1:0]  shadow_supp  [DEPTH];
  int unsigned       shadow_rank  [DEPTH];
  int unsigned       shadow_count;
  logic [TICK_W-1:0] interval_cfg;
  logic [CNT_W-1:0]  capacity_cfg;

  // verdicts predicted for accepted beats, oldest first
  krl_res_t expected_verdicts [$];
  int       mismatch_count = 0;

  function automatic void shadow_reset();
    for (int i = 0; i < DEPTH; i++) begin
      shadow_valid[i] = 1'b0;
      shadow_key[i]   = '0;
      shadow_last[i]  = '0;
      shadow_supp[i]  = '0;
      shadow_rank[i]  = 0;
    end
    shadow_count = 0;
    interval_cfg = INTERVAL_RESET;
    capacity_cfg = CAPACITY_RESET;
  endfunction

  // Predicts the verdict of one beat and updates the shadow table.
  function automatic krl_res_t rate_limit(krl_req_t beat);
    krl_res_t          res;
    int                hit_idx;
    int                slot;
    int                victim;
    int                cap;
    int unsigned       r;
    logic [TICK_W-1:0] age;
    res = '0;
    hit_idx = -1;
    if (beat.key_id == '0) begin
      // empty key: rejected, table untouched
      res.rejected = 1'b1;
    end else begin
      for (int i = 0; i < DEPTH; i++)
        if (hit_idx < 0 && shadow_valid[i] && shadow_key[i] == beat.key_id)
          hit_idx = i;
      if (hit_idx >= 0) begin
        // known key: move to front, entries more recent than it age by one
        r = shadow_rank[hit_idx];
        for (int i = 0; i < DEPTH; i++)
          if (shadow_valid[i] && shadow_rank[i] < r)
            shadow_rank[i]++;
        shadow_rank[hit_idx] = 0;
        age = beat.now_ticks - shadow_last[hit_idx];
        // backward time or a full interval since the last emit lets it through
        if (beat.now_ticks < shadow_last[hit_idx] || age >= interval_cfg) begin
          res.emit = 1'b1;
          res.suppressed_count = shadow_supp[hit_idx];
          shadow_last[hit_idx] = beat.now_ticks;
          shadow_supp[hit_idx] = '0;
        end else if (shadow_supp[hit_idx] != REP_MAX) begin
          shadow_supp[hit_idx]++;
        end
      end else begin
        // new key: capacity 0 acts as 1, above the table depth as the depth
        if (capacity_cfg == '0)
          cap = 1;
        else if (capacity_cfg > DEPTH)
          cap = DEPTH;
        else
          cap = capacity_cfg;
        // evict oldest until below capacity (covers a lowered capacity)
        while (shadow_count >= cap && shadow_count > 0) begin
          victim = -1;
          for (int i = 0; i < DEPTH; i++)
            if (shadow_valid[i] && (victim < 0 || shadow_rank[i] > shadow_rank[victim]))
              victim = i;
          if (victim < 0)
            break;
          shadow_valid[victim] = 1'b0;
          shadow_count--;
        end
        slot = -1;
        for (int i = 0; i < DEPTH; i++)
          if (slot < 0 && !shadow_valid[i])
            slot = i;
        if (slot >= 0) begin
          for (int i = 0; i < DEPTH; i++)
            if (shadow_valid[i])
              shadow_rank[i]++;
          shadow_valid[slot] = 1'b1;
          shadow_key[slot]   = beat.key_id;
          shadow_last[slot]  = beat.now_ticks;
          shadow_supp[slot]  = '0;
          shadow_rank[slot]  = 0;
          shadow_count++;
        end
        res.emit = 1'b1;
      end
    end
    res.tracked_keys = CNT_W'(shadow_count);
    return res;
  endfunction

  // --------------------------------------------------------------------------
  // Result checker. Outputs change only at rising edges, so sampling at the
  // falling edge sees each one-cycle done strobe exactly once, race free.
  // --------------------------------------------------------------------------
  task automatic flag(string what, logic [31:0] want, logic [31:0] got);
    mismatch_count++;
    $display("%0t: %s mismatch, expected %0h, actual %0h", $time, what, want, got);
  endtask

  always @(negedge clk) begin : check_results
    krl_res_t want;
    if (!rst && done) begin
      if (expected_verdicts.size() == 0) begin
        flag("unexpected result beat", '0, result);
      end else begin
        want = expected_verdicts.pop_front();
        if (result.emit !== want.emit)
          flag("emit", want.emit, result.emit);
        if (result.suppressed_count !== want.suppressed_count)
          flag("suppressed_count", want.suppressed_count, result.suppressed_count);
        if (result.rejected !== want.rejected)
          flag("rejected", want.rejected, result.rejected);
        if (result.tracked_keys !== want.tracked_keys)
          flag("tracked_keys", want.tracked_keys, result.tracked_keys);
      end
    end
  end

  // --------------------------------------------------------------------------
  // Drivers. Every task is entered and left at a rising edge.
  // --------------------------------------------------------------------------

  // One request beat. start is left high so back-to-back beats need no
  // second assignment in one step; it drops only on a gap or at idle.
  task automatic send_event(logic [KEY_W-1:0] key, logic [TICK_W-1:0] stamp, int gap);
    krl_req_t beat;
    beat.key_id    = key;
    beat.now_ticks = stamp;
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start <= 1'b1;
    req   <= beat;
    // busy is stable mid-cycle; the next rising edge takes the beat
    @(negedge clk);
    while (busy) @(negedge clk);
    @(posedge clk);
    expected_verdicts.push_back(rate_limit(beat));
  endtask

  // Stop sending and wait until every predicted verdict has come back.
  task automatic go_idle();
    start <= 1'b0;
    while (expected_verdicts.size() != 0) @(posedge clk);
    repeat (3) @(posedge clk);
  endtask

  // APB write, then a read back of the same register. psel stays high from
  // the write access phase straight into the read setup phase.
  task automatic cfg_write(logic reg_sel, logic [CFG_W-1:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {reg_sel, 2'b00};
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    // register takes the value at this edge
    if (reg_sel == REG_INTERVAL)
      interval_cfg = value;
    else
      capacity_cfg = value[CNT_W-1:0];
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
    penable <= 1'b1;
    @(negedge clk);
    if (reg_sel == REG_INTERVAL) begin
      if (prdata !== interval_cfg)
        flag("interval_ticks read back", interval_cfg, prdata);
    end else if (prdata[CNT_W-1:0] !== capacity_cfg) begin
      flag("key_capacity read back", capacity_cfg, prdata[CNT_W-1:0]);
    end
    @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    // an idle bus state so a following write starts on a fresh edge
    @(posedge clk);
  endtask

  // --------------------------------------------------------------------------
  // Tests
  // --------------------------------------------------------------------------

  // empty key on an empty table, both timestamp extremes
  task automatic test_empty_key();
    send_event('0, '0, 0);
    send_event('0, '1, 3);
  endtask

  // emit/suppress rules under the reset interval of 1000
  task automatic test_known_key();
    send_event('1, 32'd0, 0);       // fresh insert
    send_event('1, 32'd999, 0);     // one tick short of the interval
    send_event('1, 32'd500, 2);     // still inside, count rises
    send_event('0, 32'd700, 0);     // empty key between, nothing changes
    send_event('1, 32'd1000, 0);    // exactly the interval: emit, report 2
    send_event('1, 32'd999, 5);     // time went backwards: emit
    send_event(32'd1, '1, 0);       // second key at the top timestamp
    send_event(32'd1, 32'd0, 0);    // wraps back: backward time emits
  endtask

  task automatic test_interval_extremes();
    go_idle();
    cfg_write(REG_INTERVAL, '0);
    send_event(32'd1, 32'd5, 0);    // zero interval: same tick still emits
    send_event(32'd1, 32'd5, 0);
    go_idle();
    cfg_write(REG_INTERVAL, '1);
    send_event(32'd2, 32'd0, 0);
    send_event(32'd2, 32'hFFFF_FFFE, 1);  // one tick short of the full range
    send_event(32'd2, 32'hFFFF_FFFF, 0);  // exactly the full range: emit
  endtask

  // lowered capacity, LRU order, capacity 0 and above the table depth
  task automatic test_capacity_limits();
    go_idle();
    cfg_write(REG_INTERVAL, 32'd100);
    cfg_write(REG_CAPACITY, 5'd2);
    send_event(32'd10, 32'd10, 0);  // table held 3: evicts down to 1 first
    send_event(32'd11, 32'd11, 0);
    send_event(32'd10, 32'd12, 0);  // touch: 11 becomes oldest
    send_event(32'd12, 32'd13, 0);  // evicts 11
    send_event(32'd11, 32'd14, 0);  // 11 is new again
    go_idle();
    cfg_write(REG_CAPACITY, 5'd31);
    send_event(32'h8000_0000, 32'd15, 0);
    send_event(32'h7FFF_FFFF, 32'd16, 4);
    go_idle();
    cfg_write(REG_CAPACITY, 5'd0);
    send_event(32'h5555_5555, 32'hAAAA_AAAA, 0);  // capacity 0 keeps one key
    send_event(32'hAAAA_AAAA, 32'h5555_5555, 0);
  endtask

  // One random phase: keys mostly from a small pool so records get hit,
  // suppressed and evicted; timestamps creep forward with some jumps.
  task automatic run_traffic(logic [TICK_W-1:0] interval, logic [CNT_W-1:0] capacity,
                             int beats, bit gapless);
    logic [KEY_W-1:0]  pool [24];
    int                pool_n;
    int                pick;
    int                gap;
    logic [KEY_W-1:0]  key;
    logic [TICK_W-1:0] stamp;
    logic [TICK_W-1:0] clock_now;
    logic [TICK_W-1:0] span;
    go_idle();
    cfg_write(REG_INTERVAL, interval);
    cfg_write(REG_CAPACITY, capacity);
    pool_n = $urandom_range(4, 24);
    for (int i = 0; i < 24; i++) begin
      pool[i] = $urandom();
      if (pool[i] == '0)
        pool[i] = 32'd1;
    end
    if (interval == '0)
      span = 32'd16;
    else if (interval > 32'd2000)
      span = 32'd2000;
    else
      span = interval;
    clock_now = $urandom();
    for (int n = 0; n < beats; n++) begin
      pick = $urandom_range(0, 99);
      if (pick < 4)
        key = '0;
      else if (pick < 8)
        key = $urandom();
      else
        key = pool[$urandom_range(0, pool_n - 1)];
      pick = $urandom_range(0, 99);
      if (pick < 5) begin
        stamp = $urandom();
      end else if (pick < 10) begin
        stamp = clock_now - $urandom_range(1, span);
      end else begin
        clock_now = clock_now + $urandom_range(0, span / 4 + 1);
        stamp = clock_now;
      end
      if (gapless || $urandom_range(0, 3) == 0)
        gap = 0;
      else
        gap = $urandom_range(0, 16);
      send_event(key, stamp, gap);
      // now and then the sender holds off until all verdicts are back
      if ($urandom_range(0, 63) == 0)
        go_idle();
    end
  endtask

  task automatic test_random_traffic();
    run_traffic(32'd10,          5'd16, 180, 1'b0);
    run_traffic(32'd3,           5'd4,  130, 1'b0);
    run_traffic(32'd0,           5'd1,  100, 1'b1);
    run_traffic(32'd250,         5'd31, 150, 1'b0);
    run_traffic(32'hFFFF_FFFF,   5'd8,  120, 1'b0);
    run_traffic(32'd1,           5'd0,  80,  1'b1);
  endtask

  // --------------------------------------------------------------------------
  // Sequence
  // --------------------------------------------------------------------------
  initial begin
    shadow_reset();
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    test_empty_key();
    test_known_key();
    test_interval_extremes();
    test_capacity_limits();
    test_random_traffic();
    start <= 1'b0;
    for (int w = 0; w < 2000 && expected_verdicts.size() != 0; w++)
      @(posedge clk);
    repeat (40) @(posedge clk);
    if (expected_verdicts.size() != 0)
      flag("verdicts never returned", expected_verdicts.size(), 0);
    if (mismatch_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  // run limit, far above the slowest legal run
  initial begin
    #5_000_000;
    $display("simulation failed");
    $finish;
  end

endmodule
